// ===== rtl/lbc_pkg.sv =====
package lbc_pkg;

	// Fixed port widths of the block.
	localparam int CW_W      = 7;
	localparam int SYN_W     = 3;
	localparam int GEN_W     = 7;
	localparam int CFG_IDX_W = 4;
	localparam int NUM_RESET_ROWS = 4;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_CHECK  = 1'b1;

	localparam logic [GEN_W-1:0] RESET_ROWS [NUM_RESET_ROWS] = '{
		7'd97, 7'd82, 7'd52, 7'd120
	};

	typedef struct packed {
		logic             valid;
		logic             cmd;
		logic [CW_W-1:0]  word;
	} item_t;

endpackage

// ===== rtl/lbc_reduce.sv =====
module lbc_reduce #(
	parameter int K_ROWS = 4,
	parameter int N_COLS = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              restart,
	input  logic [N_COLS-1:0] gen_rows [K_ROWS],
	output logic [N_COLS-1:0] red_rows [K_ROWS],
	output logic              busy
);
	import lbc_pkg::*;

	localparam int COL_W = $clog2(N_COLS);
	localparam int PIV_W = $clog2(K_ROWS + 1);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(N_COLS - 1);

	typedef enum logic [2:0] {
		RED_LOAD = 3'b001,
		RED_RUN  = 3'b010,
		RED_DONE = 3'b100
	} red_state_t;

	red_state_t        state_q;
	logic [COL_W-1:0]  col_q;
	logic [PIV_W-1:0]  piv_q;
	logic [N_COLS-1:0] work_q [K_ROWS];
	logic [N_COLS-1:0] nxt    [K_ROWS];
	logic [N_COLS-1:0] swp    [K_ROWS];
	logic [N_COLS-1:0] piv_row;
	logic [N_COLS-1:0] fnd_row;
	logic              found;
	logic [PIV_W-1:0]  fidx;

	// One column of Gauss-Jordan elimination per cycle.
	always_comb begin
		found   = 1'b0;
		fidx    = '0;
		piv_row = '0;
		fnd_row = '0;
		for (int i = 0; i < K_ROWS; i++) begin
			if (!found && (PIV_W'(i) >= piv_q) && work_q[i][col_q]) begin
				found = 1'b1;
				fidx  = PIV_W'(i);
			end
		end
		for (int i = 0; i < K_ROWS; i++) begin
			if (PIV_W'(i) == piv_q) begin
				piv_row = work_q[i];
			end
			if (PIV_W'(i) == fidx) begin
				fnd_row = work_q[i];
			end
		end
		for (int i = 0; i < K_ROWS; i++) begin
			if (PIV_W'(i) == piv_q) begin
				swp[i] = fnd_row;
			end else if (PIV_W'(i) == fidx) begin
				swp[i] = piv_row;
			end else begin
				swp[i] = work_q[i];
			end
		end
		for (int i = 0; i < K_ROWS; i++) begin
			if (!found) begin
				nxt[i] = work_q[i];
			end else if ((PIV_W'(i) != piv_q) && swp[i][col_q]) begin
				nxt[i] = swp[i] ^ fnd_row;
			end else begin
				nxt[i] = swp[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RED_LOAD;
			col_q   <= '0;
			piv_q   <= '0;
		end else if (restart) begin
			state_q <= RED_LOAD;
		end else begin
			case (state_q)
				RED_LOAD: begin
					col_q   <= '0;
					piv_q   <= '0;
					state_q <= RED_RUN;
				end
				RED_RUN: begin
					if (found) begin
						piv_q <= piv_q + PIV_W'(1);
					end
					col_q <= col_q + COL_W'(1);
					if (col_q == LAST_COL) begin
						state_q <= RED_DONE;
					end
				end
				RED_DONE: begin
					state_q <= RED_DONE;
				end
				default: begin
					state_q <= RED_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == RED_LOAD) begin
			work_q <= gen_rows;
		end else if (state_q == RED_RUN) begin
			work_q <= nxt;
		end
	end

	assign red_rows = work_q;
	assign busy     = (state_q != RED_DONE) || restart;

endmodule

// ===== rtl/lbc_datapath.sv =====
module lbc_datapath #(
	parameter int K_ROWS = 4,
	parameter int N_COLS = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lbc_pkg::item_t            item_s1,
	input  logic [N_COLS-1:0]         red_rows [K_ROWS],
	output logic                      done,
	output logic [lbc_pkg::CW_W-1:0]  codeword,
	output logic [lbc_pkg::SYN_W-1:0] syndrome
);
	import lbc_pkg::*;

	localparam int W_A   = (N_COLS > CW_W) ? N_COLS : CW_W;
	localparam int EXT_W = (W_A > K_ROWS + SYN_W) ? W_A : K_ROWS + SYN_W;

	logic [EXT_W-1:0] w_ext;
	logic [EXT_W-1:0] row_ext [K_ROWS];
	logic [EXT_W-1:0] cw_ext;
	logic [SYN_W-1:0] syn;
	logic             done_s2;
	logic [CW_W-1:0]  codeword_s2;
	logic [SYN_W-1:0] syndrome_s2;

	// Zero padding makes word bits above N_COLS and parity columns past the
	// end of the matrix drop out without special cases.
	for (genvar c = 0; c < EXT_W; c++) begin : g_wext
		if (c < CW_W && c < N_COLS) begin : g_on
			assign w_ext[c] = item_s1.word[c];
		end else begin : g_off
			assign w_ext[c] = 1'b0;
		end
	end

	for (genvar i = 0; i < K_ROWS; i++) begin : g_rext
		assign row_ext[i] = EXT_W'(red_rows[i]);
	end

	always_comb begin
		cw_ext = '0;
		for (int i = 0; i < K_ROWS; i++) begin
			if (w_ext[i]) begin
				cw_ext = cw_ext ^ row_ext[i];
			end
		end
		for (int s = 0; s < SYN_W; s++) begin
			syn[s] = w_ext[K_ROWS + s];
			for (int i = 0; i < K_ROWS; i++) begin
				syn[s] = syn[s] ^ (w_ext[i] & row_ext[i][K_ROWS + s]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= item_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_s1.cmd == CMD_ENCODE) begin
			codeword_s2 <= cw_ext[CW_W-1:0];
			syndrome_s2 <= '0;
		end else begin
			codeword_s2 <= '0;
			syndrome_s2 <= syn;
		end
	end

	assign done     = done_s2;
	assign codeword = codeword_s2;
	assign syndrome = syndrome_s2;

endmodule

// ===== rtl/linear_block_code_encode_syndrome_unit.sv =====
// Channel   Signals                          Handshake
// --------  -------------------------------  ------------------------------
// command   start, cmd, word_bits            taken when start && !busy
// result    done, codeword, syndrome         done high for one cycle
// config    wr_en, wr_index, wr_data         written when wr_en is high
//
// An accepted item is held in item_s1, then in the s2 output registers that
// drive its result onto the ports with done; one item can be taken every
// cycle while busy is low. After reset and after every write to a generator
// row, busy stays high while the elimination sequencer reduces the matrix,
// one column per cycle. The receiver cannot stall the results.
module linear_block_code_encode_syndrome_unit #(
	parameter int K_ROWS = 4,
	parameter int N_COLS = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [lbc_pkg::CW_W-1:0]      word_bits,
	output logic                          done,
	output logic [lbc_pkg::CW_W-1:0]      codeword,
	output logic [lbc_pkg::SYN_W-1:0]     syndrome,
	input  logic                          wr_en,
	input  logic [lbc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [lbc_pkg::GEN_W-1:0]     wr_data
);
	import lbc_pkg::*;

	logic [N_COLS-1:0] gen_q    [K_ROWS];
	logic [N_COLS-1:0] red_rows [K_ROWS];
	logic              restart;
	item_t             item_s1;

	assign restart = wr_en && (32'(wr_index) < K_ROWS);

	for (genvar i = 0; i < K_ROWS; i++) begin : g_gen
		localparam logic [N_COLS-1:0] RST_ROW =
			(i < NUM_RESET_ROWS) ? N_COLS'(RESET_ROWS[i]) : '0;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				gen_q[i] <= RST_ROW;
			end else if (wr_en && (32'(wr_index) == i)) begin
				gen_q[i] <= N_COLS'(wr_data);
			end
		end
	end

	lbc_reduce #(
		.K_ROWS (K_ROWS),
		.N_COLS (N_COLS)
	) u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.gen_rows (gen_q),
		.red_rows (red_rows),
		.busy     (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1.valid <= start && !busy;
			if (start && !busy) begin
				item_s1.cmd  <= cmd;
				item_s1.word <= word_bits;
			end
		end
	end

	lbc_datapath #(
		.K_ROWS (K_ROWS),
		.N_COLS (N_COLS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_s1  (item_s1),
		.red_rows (red_rows),
		.done     (done),
		.codeword (codeword),
		.syndrome (syndrome)
	);

endmodule
